@@ rtl/vswf_pkg.sv @@
// vswf_pkg: shared types and constants for the vehicle speed window filter
// no dependencies
package vswf_pkg;
  localparam int Window = 5;
  localparam int CntW = $clog2(Window + 1);
  localparam logic [15:0] GainFwdReset = 16'd3342;
  localparam logic [15:0] GainRevReset = 16'd3189;
  localparam logic [7:0] ClutchMask = 8'h40;
  localparam logic [19:0] UsPerS = 20'd1000000;
  localparam logic [1:0] RegGainFwd = 2'd0;
  localparam logic [1:0] RegGainRev = 2'd1;
  // shift-in command for a window chain
  typedef struct packed {
    logic push;
    logic signed [15:0] value;
  } win_cmd_t;
endpackage

@@ rtl/vswf_if.sv @@
// vswf_in_if, vswf_out_if: valid/ready channels of the filter
// no dependencies
interface vswf_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [63:0] frame_payload;
  logic [23:0] elapsed_us;
  modport source (output valid, frame_payload, elapsed_us, input ready);
  modport sink (input valid, frame_payload, elapsed_us, output ready);
endinterface

interface vswf_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] speed;
  logic signed [15:0] speed_mean;
  logic signed [15:0] speed_median;
  logic signed [15:0] accel;
  logic signed [15:0] accel_mean;
  logic signed [15:0] accel_median;
  logic accel_valid;
  logic signed [15:0] steer_raw;
  logic signed [23:0] steer_degrees;
  logic clutch_engaged;
  modport source (output valid, speed, speed_mean, speed_median, accel, accel_mean,
    accel_median, accel_valid, steer_raw, steer_degrees, clutch_engaged, input ready);
  modport sink (input valid, speed, speed_mean, speed_median, accel, accel_mean,
    accel_median, accel_valid, steer_raw, steer_degrees, clutch_engaged, output ready);
endinterface

@@ rtl/vswf_cell.sv @@
// vswf_cell: one window slot; shifts to its neighbor and ranks itself
// no dependencies
module vswf_cell (
  input  logic clk,
  input  logic shift,
  input  logic signed [15:0] din,
  output logic signed [15:0] dout,
  // rank pass: a value circulates past every cell
  input  logic rank_clr,
  input  logic rank_en,
  input  logic signed [15:0] probe,
  input  logic [4:0] probe_idx,
  input  logic [4:0] my_idx,
  output logic [4:0] rank
);
  always_ff @(posedge clk) begin
    if (shift) dout <= din;
  end
  // stable rank: count smaller values, ties broken by slot index
  always_ff @(posedge clk) begin
    if (rank_clr) begin
      rank <= '0;
    end else if (rank_en) begin
      if (probe < dout || (probe == dout && probe_idx < my_idx)) rank <= rank + 5'd1;
    end
  end
endmodule

@@ rtl/vswf_window.sv @@
// vswf_window: chain of cells with serial sum and rank-based median
// depends on vswf_pkg, vswf_cell
module vswf_window (
  input  logic clk,
  input  logic rst,
  input  vswf_pkg::win_cmd_t cmd,
  input  logic start,
  output logic done,
  output logic signed [15:0] mean,
  output logic signed [15:0] median,
  output logic signed [15:0] newest
);
  localparam int W = vswf_pkg::Window;
  logic signed [15:0] data [W];
  logic [4:0] ranks [W];
  logic [vswf_pkg::CntW-1:0] count;
  logic [4:0] step;
  logic busy;
  logic signed [15:0] probe;
  logic signed [19:0] sum;
  logic signed [15:0] med;
  logic signed [15:0] med_next;
  // divide stage
  logic [1:0] phase;
  logic [19:0] rem;
  logic [19:0] mag;
  logic [15:0] q;
  logic neg;

  // ranks include invalid slots; subtract those that counted against slot i
  function automatic logic [4:0] rank_bad(input int i);
    logic [4:0] n;
    n = '0;
    for (int k = 0; k < W; k++)
      if (5'(k) >= 5'(count) && (data[k] < data[i] || (data[k] == data[i] && k < i)))
        n = n + 5'd1;
    return n;
  endfunction

  for (genvar i = 0; i < W; i++) begin : g_cell
    vswf_cell u_cell (
      .clk(clk), .shift(cmd.push),
      .din(i == 0 ? cmd.value : data[(i == 0) ? 0 : i - 1]),
      .dout(data[i]), .rank_clr(start), .rank_en(busy && phase == 2'd0),
      .probe(probe), .probe_idx(step), .my_idx(5'(i)), .rank(ranks[i]));
  end

  always_comb begin
    probe = data[0];
    for (int i = 0; i < W; i++) if (step == 5'(i)) probe = data[i];
  end

  // median: the valid slot whose rank among valid slots is count/2
  always_comb begin
    med_next = 16'sd0;
    for (int i = 0; i < W; i++) begin
      if (5'(i) < 5'(count) && ranks[i] - rank_bad(i) == 5'(count >> 1))
        med_next = data[i];
    end
  end

  assign newest = data[0];
  assign median = med;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy <= 1'b0;
      done <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (cmd.push && count != vswf_pkg::CntW'(W)) count <= count + 1'b1;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        sum <= '0;
        phase <= 2'd0;
      end else if (busy) begin
        case (phase)
          2'd0: begin
            // probe walks slot by slot; only valid slots add to the sum
            if (step < 5'(count)) sum <= sum + 20'(probe);
            if (step == 5'(W - 1)) begin
              phase <= 2'd1;
              step <= '0;
            end else begin
              step <= step + 5'd1;
            end
          end
          2'd1: begin
            neg <= sum[19];
            mag <= sum[19] ? -sum : sum;
            rem <= '0;
            q <= '0;
            step <= 5'd19;
            phase <= 2'd2;
            med <= med_next;
          end
          2'd2: begin
            // restoring divide by count, one bit a cycle
            if ({rem[18:0], mag[step]} >= 20'(count)) begin
              rem <= {rem[18:0], mag[step]} - 20'(count);
              if (step < 5'd16) q[step[3:0]] <= 1'b1;
            end else begin
              rem <= {rem[18:0], mag[step]};
            end
            if (step == 5'd0) phase <= 2'd3;
            else step <= step - 5'd1;
          end
          default: begin
            mean <= neg ? -q : q;
            busy <= 1'b0;
            done <= 1'b1;
            phase <= 2'd0;
          end
        endcase
      end
    end
  end
endmodule

@@ rtl/vehicle_speed_window_filter.sv @@
// vehicle_speed_window_filter: top level of the status frame filter
// depends on vswf_pkg, vswf_if, vswf_window, vswf_cell
//
//  channel  dir  transfer carries
//  in       in   frame_payload, elapsed_us
//  out      out  speed and window stats, accel and stats, steering, clutch
//  apb      in   gain_forward (0x0), gain_reverse (0x4)
//
// a frame steps through SDiv, SWin and SWait: the acceleration divide runs one
// quotient bit a cycle over 36 bits, SWin pushes the new acceleration once a
// previous speed exists, then both windows sum, rank and divide; the result
// is registered when both are done and holds until its transfer
// reset clears counts, gains and handshake state; window slots are undefined
// a stalled result holds in the output register; input ready waits for it
module vehicle_speed_window_filter (
  input  logic clk,
  input  logic rst,
  vswf_in_if.sink in,
  vswf_out_if.source out,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [15:0] gain_forward, gain_reverse;
  logic [2:0] state;
  localparam logic [2:0] SIdle = 3'd0, SDiv = 3'd1, SWin = 3'd2, SWait = 3'd3,
    SOut = 3'd4;
  logic [63:0] payload;
  logic [23:0] elapsed;
  logic have_prev;
  logic signed [15:0] spd, prev_spd;
  // prev minus current speed and its magnitude
  logic signed [16:0] diff;
  logic [16:0] dmag;
  // accel divide: |diff| * 1e6 / elapsed
  logic [35:0] num;
  logic [24:0] rem;
  logic [35:0] quo;
  logic [5:0] bitn;
  logic neg;
  logic signed [15:0] acc;
  vswf_pkg::win_cmd_t scmd, acmd;
  logic start, sdone, adone, sgot, agot;
  logic signed [15:0] smean, smed, amean, amed, snew, anew;
  logic signed [31:0] prod;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      vswf_pkg::RegGainFwd[0]: prdata = {16'd0, gain_forward};
      default: prdata = {16'd0, gain_reverse};
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_forward <= vswf_pkg::GainFwdReset;
      gain_reverse <= vswf_pkg::GainRevReset;
    end else if (psel && penable && pwrite) begin
      if (paddr == {vswf_pkg::RegGainFwd, 1'b0} << 1) gain_forward <= pwdata[15:0];
      else if (paddr == 3'({vswf_pkg::RegGainRev, 2'b00})) gain_reverse <= pwdata[15:0];
    end
  end

  assign in.ready = (state == SIdle);
  assign spd = $signed(in.frame_payload[15:0]);

  vswf_window u_speed (.clk(clk), .rst(rst), .cmd(scmd), .start(start), .done(sdone),
    .mean(smean), .median(smed), .newest(snew));
  vswf_window u_accel (.clk(clk), .rst(rst), .cmd(acmd), .start(start), .done(adone),
    .mean(amean), .median(amed), .newest(anew));

  // acceleration is pushed once the last quotient bit has settled
  always_comb begin
    scmd.push = in.valid && in.ready;
    scmd.value = spd;
    acmd.push = (state == SWin) && have_prev;
    acmd.value = acc;
  end
  assign prev_spd = snew;

  assign diff = $signed({prev_spd[15], prev_spd}) - $signed({spd[15], spd});
  assign dmag = diff[16] ? 17'(-diff) : 17'(diff);

  // saturate quotient; zero elapsed gives 0 for no change, else the rail of its sign
  always_comb begin
    logic [36:0] qq;
    qq = {1'b0, quo};
    if (elapsed == 24'd0) acc = (num == 36'd0) ? 16'sd0 : (neg ? -16'sd32768 : 16'sd32767);
    else if (!neg) acc = (qq > 37'd32767) ? 16'sd32767 : 16'(quo);
    else acc = (qq > 37'd32768) ? -16'sd32768 : -16'(quo);
  end

  assign prod = $signed(payload[31:16]) * $signed({1'b0, ($signed(payload[15:0]) >= 0)
    ? gain_forward : gain_reverse});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      have_prev <= 1'b0;
      out.valid <= 1'b0;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
      case (state)
        SIdle: if (in.valid) begin
          payload <= in.frame_payload;
          elapsed <= in.elapsed_us;
          // prev minus current, before the new speed shifts in
          neg <= diff[16];
          num <= dmag * vswf_pkg::UsPerS;
          rem <= '0;
          quo <= '0;
          bitn <= 6'd35;
          state <= SDiv;
        end
        SDiv: begin
          if (elapsed != 24'd0) begin
            if ({rem[23:0], num[bitn]} >= {1'b0, elapsed}) begin
              rem <= {rem[23:0], num[bitn]} - {1'b0, elapsed};
              quo[bitn] <= 1'b1;
            end else begin
              rem <= {rem[23:0], num[bitn]};
            end
          end
          if (bitn == 6'd0) begin
            state <= SWin;
          end else begin
            bitn <= bitn - 6'd1;
          end
        end
        SWin: begin
          start <= 1'b1;
          sgot <= 1'b0;
          agot <= 1'b0;
          state <= SWait;
        end
        SWait: begin
          if (sdone) sgot <= 1'b1;
          if (adone) agot <= 1'b1;
          if ((sgot || sdone) && (agot || adone)) begin
            out.valid <= 1'b1;
            out.speed <= $signed(payload[15:0]);
            out.speed_mean <= smean;
            out.speed_median <= smed;
            out.accel <= have_prev ? acc : 16'sd0;
            out.accel_mean <= have_prev ? amean : 16'sd0;
            out.accel_median <= have_prev ? amed : 16'sd0;
            out.accel_valid <= have_prev;
            out.steer_raw <= $signed(payload[31:16]);
            out.steer_degrees <= 24'(prod >>> 8);
            out.clutch_engaged <= (payload[55:48] & vswf_pkg::ClutchMask) == 8'd0;
            have_prev <= 1'b1;
            state <= SOut;
          end
        end
        default: if (out.ready) begin
          out.valid <= 1'b0;
          state <= SIdle;
        end
      endcase
    end
  end
endmodule

@@ tb/speed_filter_checker.sv @@
`timescale 1ns / 1ps
// speed_filter_checker: watches the frame, result and register channels of the filter
// depends on vswf_pkg, vswf_if
module speed_filter_checker (
  input  logic clk,
  input  logic rst,
  vswf_in_if in_ch,
  vswf_out_if out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  input  logic pready,
  output int fail_count,
  output int pending,
  output int result_count
);
  typedef struct {
    logic signed [15:0] speed;
    logic signed [15:0] speed_mean;
    logic signed [15:0] speed_median;
    logic signed [15:0] accel;
    logic signed [15:0] accel_mean;
    logic signed [15:0] accel_median;
    logic accel_valid;
    logic signed [15:0] steer_raw;
    logic signed [23:0] steer_degrees;
    logic clutch_engaged;
  } status_t;

  status_t expected_status[$];
  logic [15:0] gain_fwd, gain_rev;
  int speed_hist[vswf_pkg::Window];
  int accel_hist[vswf_pkg::Window];
  int speed_n, accel_n;

  function automatic int hist_mean(int h[vswf_pkg::Window], int n);
    int sum;
    sum = 0;
    for (int i = 0; i < n; i++) sum += h[i];
    return sum / n;
  endfunction

  function automatic int hist_median(int h[vswf_pkg::Window], int n);
    int s[vswf_pkg::Window];
    int v, j;
    for (int i = 0; i < n; i++) begin
      v = h[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    return s[n/2];
  endfunction

  function automatic int speed_change_rate(int prev, int cur, logic [23:0] dt);
    longint diff, q;
    diff = longint'(prev) - longint'(cur);
    if (dt == 0) return diff > 0 ? 32767 : (diff < 0 ? -32768 : 0);
    q = (diff * 1000000) / longint'(dt);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  // advance the window state by one frame and return its decoded status
  function automatic status_t decode_frame(logic [63:0] pl, logic [23:0] dt);
    status_t r;
    int spd, str, acc;
    longint prod;
    spd = int'($signed(pl[15:0]));
    str = int'($signed(pl[31:16]));
    r.accel = '0;
    r.accel_mean = '0;
    r.accel_median = '0;
    r.accel_valid = 1'b0;
    if (speed_n != 0) begin
      acc = speed_change_rate(speed_hist[0], spd, dt);
      for (int i = vswf_pkg::Window - 1; i > 0; i--) accel_hist[i] = accel_hist[i-1];
      accel_hist[0] = acc;
      if (accel_n < vswf_pkg::Window) accel_n++;
      r.accel = 16'(acc);
      r.accel_mean = 16'(hist_mean(accel_hist, accel_n));
      r.accel_median = 16'(hist_median(accel_hist, accel_n));
      r.accel_valid = 1'b1;
    end
    for (int i = vswf_pkg::Window - 1; i > 0; i--) speed_hist[i] = speed_hist[i-1];
    speed_hist[0] = spd;
    if (speed_n < vswf_pkg::Window) speed_n++;
    r.speed = 16'(spd);
    r.speed_mean = 16'(hist_mean(speed_hist, speed_n));
    r.speed_median = 16'(hist_median(speed_hist, speed_n));
    r.steer_raw = 16'(str);
    prod = longint'(str) * longint'(spd >= 0 ? gain_fwd : gain_rev);
    r.steer_degrees = 24'(prod >>> 8);
    r.clutch_engaged = ~(pl[55:48] & vswf_pkg::ClutchMask) != 8'hFF ? 1'b0 : 1'b1;
    return r;
  endfunction

  task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    status_t e;
    if (rst) begin
      gain_fwd <= vswf_pkg::GainFwdReset;
      gain_rev <= vswf_pkg::GainRevReset;
      speed_n = 0;
      accel_n = 0;
      expected_status.delete();
      fail_count = 0;
      result_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2:2] == vswf_pkg::RegGainFwd[0]) gain_fwd <= pwdata[15:0];
        else if (paddr[2:2] == vswf_pkg::RegGainRev[0]) gain_rev <= pwdata[15:0];
      end
      if (in_ch.valid && in_ch.ready)
        expected_status.push_back(decode_frame(in_ch.frame_payload, in_ch.elapsed_us));
      if (out_ch.valid && out_ch.ready) begin
        result_count <= result_count + 1;
        if (expected_status.size() == 0) begin
          $display("%0t unexpected result transfer, expected none actual speed %0h",
                   $time, out_ch.speed);
          fail_count++;
        end else begin
          e = expected_status.pop_front();
          check_field("speed", 24'(e.speed), 24'(out_ch.speed));
          check_field("speed_mean", 24'(e.speed_mean), 24'(out_ch.speed_mean));
          check_field("speed_median", 24'(e.speed_median), 24'(out_ch.speed_median));
          check_field("accel", 24'(e.accel), 24'(out_ch.accel));
          check_field("accel_mean", 24'(e.accel_mean), 24'(out_ch.accel_mean));
          check_field("accel_median", 24'(e.accel_median), 24'(out_ch.accel_median));
          check_field("accel_valid", 24'(e.accel_valid), 24'(out_ch.accel_valid));
          check_field("steer_raw", 24'(e.steer_raw), 24'(out_ch.steer_raw));
          check_field("steer_degrees", e.steer_degrees, out_ch.steer_degrees);
          check_field("clutch_engaged", 24'(e.clutch_engaged), 24'(out_ch.clutch_engaged));
        end
      end
    end
    pending = expected_status.size();
  end
endmodule

@@ tb/vehicle_speed_window_filter_tb.sv @@
`timescale 1ns / 1ps
// vehicle_speed_window_filter_tb: frame stimulus, gain writes and verdict for the filter
// depends on vswf_pkg, vswf_if, vehicle_speed_window_filter, speed_filter_checker
module vehicle_speed_window_filter_tb;
  localparam int StallLimit = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending, result_count;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int frames_sent = 0;
  int quiet_cycles = 0;
  int last_speed = 0;

  vswf_in_if in_ch (clk);
  vswf_out_if out_ch (clk);

  initial begin
    in_ch.valid = 1'b0;
    in_ch.frame_payload = '0;
    in_ch.elapsed_us = '0;
    out_ch.ready = 1'b0;
  end

  vehicle_speed_window_filter uut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  speed_filter_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
    .pending(pending), .result_count(result_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver throttling, redrawn every cycle
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: a run with no transfer for too long is stuck
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // setup then access phase; the register takes pwdata at the access edge
  task automatic gain_write(logic [1:0] reg_idx, logic [15:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {reg_idx[0], 2'b00};
    pwdata = {16'($urandom_range(65535)), value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // drain every result, then leave time for the divider to settle
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // one frame transfer; valid stays high into the next call unless the sender idles
  task automatic send_frame(logic [63:0] pl, logic [23:0] dt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.frame_payload = pl;
    in_ch.elapsed_us = dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    frames_sent++;
    last_speed = int'($signed(pl[15:0]));
  endtask

  function automatic logic [63:0] frame_with(int spd, int str);
    logic [63:0] pl;
    pl = {$urandom, $urandom};
    pl[15:0] = spd[15:0];
    pl[31:16] = str[15:0];
    return pl;
  endfunction

  // mostly a plausible drive cycle: small speed steps at bus-like intervals
  task automatic send_random_frames(int n);
    int spd, str, pick;
    logic [23:0] dt;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 65) spd = last_speed + $signed($urandom_range(400)) - 200;
      else if (pick < 85) spd = $signed($urandom_range(65535)) - 32768;
      else spd = $urandom_range(1) ? 32767 : -32768;
      if (spd > 32767) spd = 32767;
      if (spd < -32768) spd = -32768;
      pick = $urandom_range(99);
      if (pick < 80) str = $signed($urandom_range(4000)) - 2000;
      else str = $signed($urandom_range(65535)) - 32768;
      pick = $urandom_range(99);
      if (pick < 70) dt = 24'($urandom_range(100000, 1000));
      else if (pick < 80) dt = '0;
      else if (pick < 90) dt = 24'($urandom_range(10, 1));
      else dt = 24'($urandom_range(24'hFFFFFF));
      send_frame(frame_with(spd, str), dt);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: first frame, zero elapsed with rising and falling speed, saturation,
    // field extremes and the clutch bit both ways, under reset gains
    send_frame(64'h0000_0000_0000_0000, 24'd0);
    send_frame(64'h0000_0000_0000_0064, 24'd0);
    send_frame(64'h0040_0000_0000_0000, 24'd0);
    send_frame(64'h00BF_0000_0000_0032, 24'd0);
    send_frame(64'h0000_0000_7FFF_7FFF, 24'd1);
    send_frame(64'h0000_0000_8000_8000, 24'd1);
    send_frame(64'h0000_0000_8000_7FFF, 24'hFFFFFF);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 24'd1);
    send_frame(64'h0000_0000_0001_FFFF, 24'd3);
    send_frame(64'h0000_0000_FFFF_0000, 24'd10000);
    send_frame(64'h0000_0000_7FFF_8000, 24'd7);
    send_frame(64'h5555_5555_5555_5555, 24'h555555);
    send_frame(64'hAAAA_AAAA_AAAA_AAAA, 24'hAAAAAA);
    send_frame(64'h0000_0000_0000_03E8, 24'd20000);
    send_frame(64'h0000_0000_0000_03E8, 24'd20000);
    send_frame(64'h0000_0000_0000_0000, 24'd1);
    send_frame(64'h0000_0000_FF00_0001, 24'd1000000);
    drain_results();

    // gains at opposite extremes, sender busier than receiver
    gain_write(vswf_pkg::RegGainFwd, 16'h0000);
    gain_write(vswf_pkg::RegGainRev, 16'hFFFF);
    send_idle_pct = 31;
    recv_idle_pct = 49;
    send_random_frames(600);
    drain_results();

    gain_write(vswf_pkg::RegGainFwd, 16'hFFFF);
    gain_write(vswf_pkg::RegGainRev, 16'h0000);
    send_idle_pct = 49;
    recv_idle_pct = 31;
    send_random_frames(600);
    drain_results();

    gain_write(vswf_pkg::RegGainFwd, 16'($urandom));
    gain_write(vswf_pkg::RegGainRev, 16'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_frames(650);
    drain_results();

    $display("covered %0d frames, %0d results, four gain settings incl. 0 and 65535",
             frames_sent, result_count);
    $display("throttling on each side, zero elapsed, saturation and window fill-up");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/vswf_pkg.sv
rtl/vswf_if.sv
rtl/vswf_cell.sv
rtl/vswf_window.sv
rtl/vehicle_speed_window_filter.sv
tb/speed_filter_checker.sv
tb/vehicle_speed_window_filter_tb.sv
